@@ hw/rtl/hwsd_pkg.sv @@
// ============================================================================
// hwsd_pkg: shared types and constants of the Haar soft-threshold denoiser
// Payload structs, register indexes, controller states, command/status bundles.
// ============================================================================
package hwsd_pkg;

    localparam int MaxLen    = 64;
    localparam int AddrW     = 6;
    localparam int CntW      = 7;
    localparam int CoefW     = 28;
    localparam int LvlW      = 3;
    localparam int ThrW      = 27;
    localparam int InvSqrt2  = 23170;

    localparam logic [1:0] RegMaxLevels = 2'd0;
    localparam logic [1:0] RegThreshold = 2'd1;
    localparam logic [1:0] RegMode      = 2'd2;

    typedef struct packed {
        logic signed [15:0] sample;
        logic               last;
    } in_item_t;

    typedef struct packed {
        logic signed [CoefW-1:0] value;
        logic                    final_res;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_PAD,
        ST_FWD_RD,
        ST_FWD_WR,
        ST_FWD_CPY,
        ST_THR,
        ST_INV_RD,
        ST_INV_WR,
        ST_INV_CPY,
        ST_OUT_RD,
        ST_OUT_WAIT,
        ST_OUT
    } state_t;

    // memory operation selected by the controller
    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_PAD,
        OP_BFLY_RD,
        OP_BFLY_WR,
        OP_COPY,
        OP_THR,
        OP_READ
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [AddrW-1:0] idx;      // pair index, entry index, etc.
        logic [AddrW-1:0] seg;      // half length of current level
        logic             inverse;
        logic             phase;    // 0: first entry, 1: second
        logic             latch_out;
    } cmd_t;

    typedef struct packed {
        logic signed [CoefW-1:0] rd_value;
    } stat_t;

endpackage

@@ hw/rtl/hwsd_datapath.sv @@
// ============================================================================
// hwsd_datapath: work store, scratch store and shared Haar butterfly
// One read and one write per store per cycle; read data registered.
// ============================================================================
module hwsd_datapath (
    input  logic                        clk,
    input  hwsd_pkg::cmd_t              cmd,
    input  logic signed [15:0]          load_sample,
    input  logic [hwsd_pkg::ThrW-1:0]   thr,
    output hwsd_pkg::stat_t             stat
);
    import hwsd_pkg::*;

    logic signed [CoefW-1:0] work_mem [MaxLen];
    logic signed [CoefW-1:0] scr_mem  [MaxLen];
    logic signed [CoefW-1:0] work_rd_reg;
    logic signed [CoefW-1:0] scr_rd_reg;
    logic signed [CoefW-1:0] a_reg;
    logic signed [CoefW-1:0] b_reg;
    logic signed [CoefW:0]   dif_reg;

    logic [AddrW-1:0]        rd_addr;
    logic [AddrW-1:0]        wr_addr;
    logic                    wr_en;
    logic signed [CoefW-1:0] wr_data;
    logic signed [CoefW-1:0] scaled;
    logic signed [CoefW:0]   sum_c;
    logic signed [CoefW:0]   sel_in;
    logic signed [CoefW-1:0] thr_out;

    // scale by 1/sqrt2 with rounding and saturation
    function automatic logic signed [CoefW-1:0] scale_f(input logic signed [CoefW:0] x);
        logic signed [CoefW+16:0] p;
        logic signed [CoefW+1:0]  q;
        p = x * $signed({1'b0, 15'(InvSqrt2)}) + (CoefW+17)'(16384);
        q = p[CoefW+16:15];
        if (q > (CoefW+2)'((2**(CoefW-1))-1))
            scale_f = {1'b0, {(CoefW-1){1'b1}}};
        else if (q < -(CoefW+2)'(2**(CoefW-1)))
            scale_f = {1'b1, {(CoefW-1){1'b0}}};
        else
            scale_f = q[CoefW-1:0];
    endfunction

    // butterfly output select; phase 0 uses the live sum, phase 1 the held difference
    always_comb
    begin
        sum_c  = {a_reg[CoefW-1], a_reg} + {work_rd_reg[CoefW-1], work_rd_reg};
        sel_in = cmd.phase ? dif_reg : sum_c;
        scaled = scale_f(sel_in);
    end

    // soft threshold on the registered read value
    always_comb
    begin
        logic signed [CoefW:0] d;
        logic signed [CoefW:0] t;
        d = {work_rd_reg[CoefW-1], work_rd_reg};
        t = {2'b00, thr};
        if (d > t)
            thr_out = CoefW'(d - t);
        else if (d < -t)
            thr_out = CoefW'(d + t);
        else
            thr_out = '0;
    end

    // read address: forward reads pairs 2i,2i+1; inverse reads i, seg+i
    always_comb
    begin
        rd_addr = cmd.idx;
        if (cmd.op == OP_BFLY_RD)
        begin
            if (cmd.inverse)
                rd_addr = cmd.phase ? AddrW'(cmd.seg + cmd.idx) : cmd.idx;
            else
                rd_addr = {cmd.idx[AddrW-2:0], cmd.phase};
        end
    end

    // work store write port
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = cmd.idx;
        wr_data = scr_rd_reg;
        unique case (cmd.op)
            OP_LOAD:
            begin
                wr_en   = 1'b1;
                wr_data = CoefW'({{(CoefW-20){load_sample[15]}}, load_sample, 4'b0000});
            end
            OP_PAD:
            begin
                wr_en   = 1'b1;
                wr_data = '0;
            end
            OP_COPY:
            begin
                wr_en   = cmd.phase;
                wr_data = scr_rd_reg;
            end
            OP_THR:
            begin
                wr_en   = cmd.phase;
                wr_data = thr_out;
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    // work store
    always_ff @(posedge clk)
    begin
        if (wr_en)
            work_mem[wr_addr] <= wr_data;
        work_rd_reg <= work_mem[rd_addr];
    end

    // scratch store: written by butterflies, read by copy pass
    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_BFLY_WR)
        begin
            if (cmd.inverse)
                scr_mem[{cmd.idx[AddrW-2:0], cmd.phase}] <= scaled;
            else
                scr_mem[cmd.phase ? AddrW'(cmd.seg + cmd.idx) : cmd.idx] <= scaled;
        end
        scr_rd_reg <= scr_mem[cmd.idx];
    end

    // operand capture and butterfly difference for the second write
    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_BFLY_RD && cmd.phase)
            a_reg <= work_rd_reg;
        if (cmd.op == OP_BFLY_WR && !cmd.phase)
            dif_reg <= {a_reg[CoefW-1], a_reg} - {work_rd_reg[CoefW-1], work_rd_reg};
        if (cmd.latch_out)
            b_reg <= work_rd_reg;
    end

    assign stat.rd_value = b_reg;

endmodule

@@ hw/rtl/hwsd_ctrl.sv @@
// ============================================================================
// hwsd_ctrl: sequencer of the load, forward, threshold, inverse and output passes
// Drives the datapath by command bundle; owns the output register.
// ============================================================================
module hwsd_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        in_last,
    input  logic [hwsd_pkg::LvlW-1:0]   max_levels,
    input  logic                        mode,
    output hwsd_pkg::cmd_t              cmd,
    input  hwsd_pkg::stat_t             stat,
    output hwsd_pkg::out_item_t         out_item,
    output logic                        out_valid,
    input  logic                        out_ready
);
    import hwsd_pkg::*;

    state_t            state_reg, state_next;
    logic [CntW-1:0]   n_reg, n_next;
    logic [CntW-1:0]   p_reg, p_next;
    logic [LvlW-1:0]   lv_reg, lv_next;
    logic [LvlW-1:0]   lvl_reg, lvl_next;
    logic [CntW-1:0]   i_reg, i_next;
    logic              ph_reg, ph_next;
    logic              mode_reg, mode_next;
    logic [CntW-1:0]   cnt_reg;    // results to emit
    logic              ov_reg, ov_next;
    out_item_t         out_reg;
    logic [CntW-1:0]   seg;
    logic [CntW-1:0]   lim;
    logic              acc;
    logic [LvlW-1:0]   lg;
    logic [CntW-1:0]   pcalc;

    assign acc = in_valid && in_ready;
    assign out_item  = out_reg;
    assign out_valid = ov_reg;

    // padded length and its log2 from the sample count
    always_comb
    begin
        lg = '0;
        for (int k = 1; k <= AddrW; k++)
        begin
            if (n_next > CntW'(1 << (k-1)))
                lg = LvlW'(k);
        end
        pcalc = CntW'(1) << lg;
    end

    // half length of the current level
    assign seg = p_reg >> (lvl_reg + LvlW'(1));

    // next state
    always_comb
    begin
        state_next = state_reg;
        n_next = n_reg;
        p_next = p_reg;
        lv_next = lv_reg;
        lvl_next = lvl_reg;
        i_next = i_reg;
        ph_next = ph_reg;
        mode_next = mode_reg;
        lim = '0;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (acc)
                begin
                    if (n_reg < CntW'(MaxLen))
                        n_next = n_reg + CntW'(1);
                    if (in_last)
                    begin
                        p_next = pcalc;
                        lv_next = (max_levels == '0 || max_levels > lg) ? lg : max_levels;
                        mode_next = mode;
                        lvl_next = '0;
                        i_next = n_next;
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD:
            begin
                if (i_reg >= p_reg)
                begin
                    i_next = '0;
                    ph_next = 1'b0;
                    state_next = (lv_reg == '0) ? (mode_reg ? ST_OUT_RD : ST_OUT_RD)
                                                : ST_FWD_RD;
                end
                else
                    i_next = i_reg + CntW'(1);
            end
            ST_FWD_RD, ST_INV_RD:
            begin
                // two reads: phase 0 then phase 1
                ph_next = ~ph_reg;
                if (ph_reg)
                    state_next = (state_reg == ST_FWD_RD) ? ST_FWD_WR : ST_INV_WR;
            end
            ST_FWD_WR, ST_INV_WR:
            begin
                ph_next = ~ph_reg;
                if (ph_reg)
                begin
                    if (i_reg + CntW'(1) >= seg)
                    begin
                        i_next = '0;
                        state_next = (state_reg == ST_FWD_WR) ? ST_FWD_CPY : ST_INV_CPY;
                    end
                    else
                    begin
                        i_next = i_reg + CntW'(1);
                        state_next = (state_reg == ST_FWD_WR) ? ST_FWD_RD : ST_INV_RD;
                    end
                end
            end
            ST_FWD_CPY, ST_INV_CPY, ST_THR:
            begin
                // phase 0 reads entry i, phase 1 writes it back
                lim = (state_reg == ST_THR) ? p_reg : (seg << 1);
                ph_next = ~ph_reg;
                if (ph_reg)
                begin
                    if (i_reg + CntW'(1) >= lim)
                    begin
                        i_next = '0;
                        priority if (state_reg == ST_FWD_CPY)
                        begin
                            if (lvl_reg + LvlW'(1) >= lv_reg)
                            begin
                                if (mode_reg)
                                    state_next = ST_OUT_RD;
                                else
                                begin
                                    i_next = CntW'(p_reg >> lv_reg);
                                    state_next = ST_THR;
                                end
                            end
                            else
                            begin
                                lvl_next = lvl_reg + LvlW'(1);
                                state_next = ST_FWD_RD;
                            end
                        end
                        else if (state_reg == ST_THR)
                        begin
                            lvl_next = lv_reg - LvlW'(1);
                            state_next = ST_INV_RD;
                        end
                        else
                        begin
                            if (lvl_reg == '0)
                                state_next = ST_OUT_RD;
                            else
                            begin
                                lvl_next = lvl_reg - LvlW'(1);
                                state_next = ST_INV_RD;
                            end
                        end
                    end
                    else
                        i_next = i_reg + CntW'(1);
                end
            end
            ST_OUT_RD:
                state_next = ST_OUT_WAIT;
            ST_OUT_WAIT:
                state_next = ST_OUT;
            ST_OUT:
            begin
                if (!ov_reg || out_ready)
                begin
                    if (i_reg + CntW'(1) >= cnt_reg)
                    begin
                        n_next = '0;
                        i_next = '0;
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        i_next = i_reg + CntW'(1);
                        state_next = ST_OUT_RD;
                    end
                end
            end
            default:
                state_next = ST_LOAD;
        endcase
    end

    // datapath commands
    always_comb
    begin
        cmd = '0;
        cmd.op = OP_NONE;
        cmd.idx = i_reg[AddrW-1:0];
        cmd.seg = seg[AddrW-1:0];
        cmd.phase = ph_reg;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_LOAD:
            begin
                in_ready = 1'b1;
                cmd.idx = n_reg[AddrW-1:0];
                if (acc && n_reg < CntW'(MaxLen))
                    cmd.op = OP_LOAD;
            end
            ST_PAD:
                if (i_reg < p_reg)
                    cmd.op = OP_PAD;
            ST_FWD_RD:
                cmd.op = OP_BFLY_RD;
            ST_INV_RD:
            begin
                cmd.op = OP_BFLY_RD;
                cmd.inverse = 1'b1;
            end
            ST_FWD_WR:
                cmd.op = OP_BFLY_WR;
            ST_INV_WR:
            begin
                cmd.op = OP_BFLY_WR;
                cmd.inverse = 1'b1;
            end
            ST_FWD_CPY, ST_INV_CPY:
                cmd.op = OP_COPY;
            ST_THR:
                cmd.op = OP_THR;
            ST_OUT_RD:
                cmd.op = OP_READ;
            ST_OUT_WAIT:
                cmd.latch_out = 1'b1;
            default:
                cmd.op = OP_NONE;
        endcase
    end

    // output register
    always_comb
    begin
        ov_next = ov_reg;
        if (ov_reg && out_ready)
            ov_next = 1'b0;
        if (state_reg == ST_OUT && (!ov_reg || out_ready))
            ov_next = 1'b1;
    end

    always_ff @(posedge clk)
    begin
        logic signed [CoefW:0]   r;
        logic signed [CoefW-4:0] q;
        if (state_reg == ST_OUT && (!ov_reg || out_ready))
        begin
            r = {stat.rd_value[CoefW-1], stat.rd_value} + (CoefW+1)'(8);
            q = r[CoefW:4];
            out_reg.final_res <= (i_reg + CntW'(1) >= cnt_reg);
            if (mode_reg)
                out_reg.value <= stat.rd_value;
            else if (q > (CoefW-3)'(32767))
                out_reg.value <= CoefW'(32767);
            else if (q < -(CoefW-3)'(32768))
                out_reg.value <= -CoefW'(32768);
            else
                out_reg.value <= CoefW'(q);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            n_reg <= '0;
            p_reg <= '0;
            lv_reg <= '0;
            lvl_reg <= '0;
            i_reg <= '0;
            ph_reg <= 1'b0;
            mode_reg <= 1'b0;
            ov_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            n_reg <= n_next;
            p_reg <= p_next;
            lv_reg <= lv_next;
            lvl_reg <= lvl_next;
            i_reg <= i_next;
            ph_reg <= ph_next;
            mode_reg <= mode_next;
            ov_reg <= ov_next;
            if (state_reg == ST_LOAD && acc && in_last)
                cnt_reg <= mode ? pcalc : n_next;
        end
    end

endmodule

@@ hw/rtl/haar_wavelet_soft_threshold_denoise_unit.sv @@
// ============================================================================
// haar_wavelet_soft_threshold_denoise_unit: Haar DWT soft-threshold denoiser
// Loads a block, runs forward passes (then threshold/inverse unless mode is set) over one work store.
// ============================================================================
//  channel   direction  handshake          payload
//  in        input      in_valid/in_ready  in_item_t  (sample, last)
//  out       output     out_valid/out_ready out_item_t (value, final_res)
//  cfg       APB        psel/penable/...   max_levels, threshold, mode
//
//  Loading accepts one sample per cycle. After last, the block is zero
//  padded to a power of two; each butterfly pair is read and written
//  in two phases and each copy/threshold entry is read, then written
//  back. Each result passes read, wait and output states plus stalls.
//  Reset clears the controller and registers; the stores are not cleared.
module haar_wavelet_soft_threshold_denoise_unit (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  hwsd_pkg::in_item_t    in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output hwsd_pkg::out_item_t   out_data,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [3:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);
    import hwsd_pkg::*;

    logic [LvlW-1:0] max_levels_reg;
    logic [ThrW-1:0] threshold_reg;
    logic            mode_reg;
    cmd_t            cmd;
    stat_t           stat;
    logic            wr;

    assign pready = 1'b1;
    assign wr = psel && penable && pwrite;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_levels_reg <= '0;
            threshold_reg <= '0;
            mode_reg <= 1'b0;
        end
        else if (wr)
        begin
            if (paddr[3:2] == RegMaxLevels)
                max_levels_reg <= pwdata[LvlW-1:0];
            if (paddr[3:2] == RegThreshold)
                threshold_reg <= pwdata[ThrW-1:0];
            if (paddr[3:2] == RegMode)
                mode_reg <= pwdata[0];
        end
    end

    // register readback
    always_comb
    begin
        prdata = '0;
        if (paddr[3:2] == RegMaxLevels)
            prdata = 32'(max_levels_reg);
        else if (paddr[3:2] == RegThreshold)
            prdata = 32'(threshold_reg);
        else if (paddr[3:2] == RegMode)
            prdata = 32'(mode_reg);
    end

    hwsd_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_last    (in_data.last),
        .max_levels (max_levels_reg),
        .mode       (mode_reg),
        .cmd        (cmd),
        .stat       (stat),
        .out_item   (out_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready)
    );

    hwsd_datapath u_dp (
        .clk         (clk),
        .cmd         (cmd),
        .load_sample (in_data.sample),
        .thr         (threshold_reg),
        .stat        (stat)
    );

    // a pending result holds while stalled
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // input is ready only while the datapath command is load or none
    a_no_in_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> cmd.op == OP_LOAD || cmd.op == OP_NONE)
        else $error("input ready during processing");

endmodule
